/* hdl/nsv_pkg.sv */
// Package: position and character constants, the result struct and hex digit helpers for the NMEA sentence validator.
`default_nettype none

package nsv_pkg;

  localparam int unsigned POS_W = 4;

  localparam logic [POS_W-1:0] POS_SAT       = POS_W'(9);
  localparam logic [POS_W-1:0] POS_HDR_LETTER = POS_W'(3);
  localparam logic [POS_W-1:0] POS_HDR_LAST   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_BODY       = POS_W'(4);
  localparam logic [POS_W-1:0] POS_MIN_LAST   = POS_W'(8);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D9     = 8'h39;

  typedef struct packed {
    logic [7:0] received_sum;
    logic [7:0] computed_sum;
    logic       checksum_ok;
    logic       well_formed;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_D0) && (c <= CH_D9);
  endfunction

  function automatic logic is_upper_hex(input logic [7:0] c);
    return (c >= CH_UA) && (c <= CH_UF);
  endfunction

  function automatic logic is_lower_hex(input logic [7:0] c);
    return (c >= CH_LA) && (c <= CH_LF);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || is_upper_hex(c) || is_lower_hex(c);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (is_digit(c)) begin
      v = c - CH_D0;
    end else if (is_upper_hex(c)) begin
      v = c - CH_UA + 8'd10;
    end else if (is_lower_hex(c)) begin
      v = c - CH_LA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/nmea_sentence_validator.sv */
// Top level: streaming NMEA sentence format and checksum validator.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: data_byte; s_tlast: line_end
//  m_*     | out | m_tvalid/m_tready  | m_tdata: computed_sum, received_sum;
//          |     |                    | m_tuser: well_formed, checksum_ok
//
// One byte is taken per cycle while s_tready is high; the line state updates in the accepting cycle.
// The result of a line appears in the result register in the cycle after its last byte is accepted.
// s_tready drops only while the result register is full and m_tready is low.
// rst is synchronous: it clears the line state and empties the result register.
`default_nettype none

module nmea_sentence_validator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // line_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] computed_sum, [15:8] received_sum
  output logic [1:0]       m_tuser    // [0] well_formed, [1] checksum_ok
);

  logic [nsv_pkg::POS_W-1:0] byte_position;
  logic                      header_ok;
  logic                      body_ok;
  logic [7:0]                running_xor;
  logic [7:0]                tail_window [3];

  logic                      header_ok_next;
  logic                      body_ok_next;
  logic [7:0]                running_xor_next;
  logic                      hex_ok;
  logic [7:0]                recv;
  logic                      wf;
  logic                      accept;
  nsv_pkg::result_t          result;
  nsv_pkg::result_t          result_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    header_ok_next = header_ok;
    if (byte_position == '0 && s_tdata != nsv_pkg::CH_DOLLAR) begin
      header_ok_next = 1'b0;
    end
    if (byte_position == nsv_pkg::POS_W'(1) && s_tdata != nsv_pkg::CH_G) begin
      header_ok_next = 1'b0;
    end
    if (byte_position == nsv_pkg::POS_W'(2) && s_tdata != nsv_pkg::CH_P) begin
      header_ok_next = 1'b0;
    end
    if (byte_position >= nsv_pkg::POS_HDR_LETTER && byte_position <= nsv_pkg::POS_HDR_LAST &&
        !(s_tdata >= nsv_pkg::CH_UA && s_tdata <= nsv_pkg::CH_UZ)) begin
      header_ok_next = 1'b0;
    end

    body_ok_next     = body_ok;
    running_xor_next = running_xor;
    if (byte_position >= nsv_pkg::POS_BODY) begin
      if (tail_window[2] == nsv_pkg::CH_STAR || tail_window[2] == nsv_pkg::CH_DOLLAR) begin
        body_ok_next = 1'b0;
      end
      running_xor_next = running_xor ^ tail_window[2];
    end

    hex_ok = nsv_pkg::is_hex(tail_window[0]) && nsv_pkg::is_hex(s_tdata);
    recv   = hex_ok ? {nsv_pkg::hex_val(tail_window[0]), nsv_pkg::hex_val(s_tdata)} : 8'h00;
    wf     = (byte_position >= nsv_pkg::POS_MIN_LAST) && header_ok_next && body_ok_next &&
             (tail_window[1] == nsv_pkg::CH_STAR) && hex_ok;

    result_next.well_formed  = wf;
    result_next.checksum_ok  = wf && (recv == running_xor_next);
    result_next.computed_sum = running_xor_next;
    result_next.received_sum = recv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      header_ok      <= 1'b1;
      body_ok        <= 1'b1;
      running_xor    <= 8'h00;
      tail_window[0] <= 8'h00;
      tail_window[1] <= 8'h00;
      tail_window[2] <= 8'h00;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        if (s_tlast) begin
          byte_position  <= '0;
          header_ok      <= 1'b1;
          body_ok        <= 1'b1;
          running_xor    <= 8'h00;
          tail_window[0] <= 8'h00;
          tail_window[1] <= 8'h00;
          tail_window[2] <= 8'h00;
          m_tvalid       <= 1'b1;
        end else begin
          header_ok      <= header_ok_next;
          body_ok        <= body_ok_next;
          running_xor    <= running_xor_next;
          tail_window[2] <= tail_window[1];
          tail_window[1] <= tail_window[0];
          tail_window[0] <= s_tdata;
          if (byte_position < nsv_pkg::POS_SAT) begin
            byte_position <= byte_position + nsv_pkg::POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      result <= result_next;
    end
  end

  assign m_tdata = {result.received_sum, result.computed_sum};
  assign m_tuser = {result.checksum_ok, result.well_formed};

  a_ok_implies_wf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
    else $error("checksum_ok without well_formed");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("last byte accepted but no result");

  a_mid_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tlast) |=> !m_tvalid)
    else $error("result raised by a byte that is not last");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= nsv_pkg::POS_SAT)
    else $error("byte position past saturation");

endmodule

`default_nettype wire
